>>> rtl/dcc_pkg.sv
// Shared widths, word types and helpers for the distance constraint correction block.
package dcc_pkg;

    localparam int COORD_W  = 21;
    localparam int TARGET_W = 21;
    localparam int DEV_W    = 24;
    localparam int WORD_W   = 63;

    localparam int DIFF_W = COORD_W + 1;          // first - second
    localparam int SUM_W  = 2 * DIFF_W;           // sum of squares
    localparam int ROOT_W = DIFF_W;               // floor sqrt of the sum
    localparam int REM_W  = ROOT_W + 2;           // sqrt partial remainder
    localparam int PROD_W = DIFF_W + DEV_W;       // d * dev
    localparam int NUM_W  = PROD_W + 1;           // |d * dev| + len
    localparam int DEN_W  = ROOT_W + 1;           // 2 * len
    localparam int QUO_W  = NUM_W - DEN_W;        // quotient bits, one per divide step
    localparam int PUSH_W = QUO_W + 1;
    localparam int SAT_W  = PUSH_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_SATISFIED  = 2'd0,
        KIND_SEPARATED  = 2'd1,
        KIND_COINCIDENT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target_distance;
        logic [WORD_W-1:0]   first_position;
        logic [WORD_W-1:0]   second_position;
        logic [WORD_W-1:0]   first_shift_in;
        logic [WORD_W-1:0]   second_shift_in;
    } in_word_t;

    typedef struct packed {
        logic signed [DEV_W-1:0] deviation;
        logic [WORD_W-1:0]       first_shift_out;
        logic [WORD_W-1:0]       second_shift_out;
    } out_word_t;

    // classified word handed from front to back
    typedef struct packed {
        kind_t                  kind;
        logic [DEV_W-1:0]       dev;
        logic [ROOT_W-1:0]      len;
        logic [2:0][DIFF_W-1:0] d;
        logic [WORD_W-1:0]      acc0;
        logic [WORD_W-1:0]      acc1;
    } mid_word_t;

    function automatic logic signed [COORD_W-1:0] comp(input logic [WORD_W-1:0] w,
                                                       input logic [1:0] k);
        return w[k*COORD_W +: COORD_W];
    endfunction

endpackage

>>> rtl/dcc_front.sv
// Front end: separation vector, squared length, pipelined square root, classification.
module dcc_front
    import dcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_word_t  item,
    output logic      mid_valid,
    input  logic      mid_full,
    output mid_word_t mid
);

    typedef struct packed {
        logic [TARGET_W-1:0]    target;
        logic [2:0][DIFF_W-1:0] d;
        logic [WORD_W-1:0]      acc0;
        logic [WORD_W-1:0]      acc1;
    } carry_t;

    logic adv;

    logic                   s0_valid_reg;
    carry_t                 s0_reg;
    logic [2:0][DIFF_W-1:0] d_next;

    logic                   s1_valid_reg;
    carry_t                 s1_reg;
    logic [2:0][SUM_W-1:0]  sq_reg;
    logic [2:0][SUM_W-1:0]  sq_next;

    logic              rt_valid_reg [0:ROOT_W];
    carry_t            rt_carry_reg [0:ROOT_W];
    logic [SUM_W-1:0]  rt_rad_reg   [0:ROOT_W];
    logic [REM_W-1:0]  rt_rem_reg   [0:ROOT_W];
    logic [ROOT_W-1:0] rt_root_reg  [0:ROOT_W];

    logic              cl_valid_reg;
    mid_word_t         cl_reg;
    mid_word_t         cl_next;

    assign adv       = !(cl_valid_reg && mid_full);
    assign full      = !adv;
    assign mid_valid = cl_valid_reg;
    assign mid       = cl_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = DIFF_W'(comp(item.first_position, 2'(k)))
                      - DIFF_W'(comp(item.second_position, 2'(k)));
            sq_next[k] = SUM_W'($signed(s0_reg.d[k]) * $signed(s0_reg.d[k]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            cl_valid_reg <= 1'b0;
            for (int j = 0; j <= ROOT_W; j++)
            begin
                rt_valid_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s0_valid_reg    <= push;
            s1_valid_reg    <= s0_valid_reg;
            rt_valid_reg[0] <= s1_valid_reg;
            for (int j = 1; j <= ROOT_W; j++)
            begin
                rt_valid_reg[j] <= rt_valid_reg[j-1];
            end
            cl_valid_reg <= rt_valid_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg.target <= item.target_distance;
            s0_reg.d      <= d_next;
            s0_reg.acc0   <= item.first_shift_in;
            s0_reg.acc1   <= item.second_shift_in;
            s1_reg        <= s0_reg;
            sq_reg        <= sq_next;
            rt_carry_reg[0] <= s1_reg;
            rt_rad_reg[0]   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            rt_rem_reg[0]   <= '0;
            rt_root_reg[0]  <= '0;
            cl_reg          <= cl_next;
        end
    end

    // one result bit per stage, two radicand bits consumed per stage
    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        logic [REM_W:0] cur;
        logic [REM_W:0] trial;
        logic [REM_W:0] diff;
        logic           ge;

        assign cur   = {rt_rem_reg[j][REM_W-2:0], rt_rad_reg[j][SUM_W-1 -: 2]};
        assign trial = {1'b0, rt_root_reg[j], 2'b01};
        assign diff  = cur - trial;
        assign ge    = cur >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_carry_reg[j+1] <= rt_carry_reg[j];
                rt_rad_reg[j+1]   <= {rt_rad_reg[j][SUM_W-3:0], 2'b00};
                rt_rem_reg[j+1]   <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
                rt_root_reg[j+1]  <= {rt_root_reg[j][ROOT_W-2:0], ge};
            end
        end
    end

    always_comb
    begin
        cl_next.len  = rt_root_reg[ROOT_W];
        cl_next.dev  = DEV_W'(rt_carry_reg[ROOT_W].target) - DEV_W'(rt_root_reg[ROOT_W]);
        cl_next.d    = rt_carry_reg[ROOT_W].d;
        cl_next.acc0 = rt_carry_reg[ROOT_W].acc0;
        cl_next.acc1 = rt_carry_reg[ROOT_W].acc1;
        if (cl_next.dev == '0)
        begin
            cl_next.kind = KIND_SATISFIED;
        end
        else if (rt_root_reg[ROOT_W] == '0)
        begin
            cl_next.kind = KIND_COINCIDENT;
        end
        else
        begin
            cl_next.kind = KIND_SEPARATED;
        end
    end

endmodule

>>> rtl/dcc_queue.sv
// Short queue of classified words between front and back.
module dcc_queue
    import dcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  mid_word_t din,
    output logic      empty,
    input  logic      pop,
    output mid_word_t dout
);

    mid_word_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

`ifndef ASSERT_OFF
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |=> (push && $stable(din)))
        else $error("queue word dropped or changed while full");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
`endif

endmodule

>>> rtl/dcc_back.sv
// Back end: push products, pipelined rounding divide, saturating update, result queue.
module dcc_back
    import dcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mid_empty,
    output logic      mid_pop,
    input  mid_word_t mid,
    output logic      empty,
    input  logic      pop,
    output out_word_t result
);

    logic adv;

    logic                   b0_valid_reg;
    mid_word_t              b0_reg;
    logic [2:0][PROD_W-1:0] prod_reg;
    logic [2:0][PROD_W-1:0] prod_next;

    logic [2:0][NUM_W-1:0]  num_next;
    logic [2:0]             neg_next;
    logic [DEV_W-1:0]       dev_mag;
    logic [DEV_W-1:0]       half_mag;
    logic signed [DEV_W-1:0] half_next;

    logic                    dv_valid_reg [0:QUO_W];
    mid_word_t               dv_word_reg  [0:QUO_W];
    logic [2:0]              dv_neg_reg   [0:QUO_W];
    logic signed [DEV_W-1:0] dv_half_reg  [0:QUO_W];
    logic [2:0][DEN_W-1:0]   dv_r_reg     [0:QUO_W];
    logic [2:0][QUO_W-1:0]   dv_low_reg   [0:QUO_W];
    logic [2:0][QUO_W-1:0]   dv_q_reg     [0:QUO_W];

    out_word_t        fin_next;
    out_word_t        oq_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] oq_wr_reg;
    logic [PTR_W-1:0] oq_rd_reg;
    logic [CNT_W-1:0] oq_cnt_reg;
    logic             oq_full;
    logic             oq_push;
    logic             oq_pop;

    function automatic logic [COORD_W-1:0] sat(input logic signed [SAT_W-1:0] v);
        if (&v[SAT_W-1:COORD_W-1] || ~|v[SAT_W-1:COORD_W-1])
        begin
            return v[COORD_W-1:0];
        end
        return v[SAT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    assign oq_full = oq_cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign empty   = oq_cnt_reg == '0;
    assign adv     = !(dv_valid_reg[QUO_W] && oq_full);
    assign mid_pop = adv && !mid_empty;
    assign oq_push = adv && dv_valid_reg[QUO_W];
    assign oq_pop  = pop && !empty;
    assign result  = oq_mem_reg[oq_rd_reg];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k] = PROD_W'($signed(mid.d[k]) * $signed(mid.dev));
            neg_next[k]  = prod_reg[k][PROD_W-1];
            // magnitude taken at product width before widening
            num_next[k]  = NUM_W'(PROD_W'(neg_next[k] ? -prod_reg[k] : prod_reg[k]))
                         + NUM_W'(b0_reg.len);
        end
        // half of dev, ties away from zero
        dev_mag   = b0_reg.dev[DEV_W-1] ? -b0_reg.dev : b0_reg.dev;
        half_mag  = (dev_mag + 1'b1) >> 1;
        half_next = b0_reg.dev[DEV_W-1] ? -$signed(half_mag) : $signed(half_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg <= 1'b0;
            for (int j = 0; j <= QUO_W; j++)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            b0_valid_reg    <= !mid_empty;
            dv_valid_reg[0] <= b0_valid_reg;
            for (int j = 1; j <= QUO_W; j++)
            begin
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_reg         <= mid;
            prod_reg       <= prod_next;
            dv_word_reg[0] <= b0_reg;
            dv_neg_reg[0]  <= neg_next;
            dv_half_reg[0] <= half_next;
            for (int k = 0; k < 3; k++)
            begin
                dv_r_reg[0][k]   <= num_next[k][NUM_W-1:QUO_W];
                dv_low_reg[0][k] <= num_next[k][QUO_W-1:0];
                dv_q_reg[0][k]   <= '0;
            end
        end
    end

    // restoring divide by 2*len, one quotient bit per stage
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        logic [2:0][DEN_W-1:0] r_next;
        logic [2:0][QUO_W-1:0] q_next;
        logic [DEN_W-1:0]      den;

        assign den = {dv_word_reg[j].len, 1'b0};

        always_comb
        begin
            logic [DEN_W:0] cur;
            logic [DEN_W:0] diff;
            for (int k = 0; k < 3; k++)
            begin
                cur       = {dv_r_reg[j][k], dv_low_reg[j][k][QUO_W-1]};
                diff      = cur - {1'b0, den};
                r_next[k] = (cur >= {1'b0, den}) ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
                q_next[k] = {dv_q_reg[j][k][QUO_W-2:0], cur >= {1'b0, den}};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_word_reg[j+1] <= dv_word_reg[j];
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_half_reg[j+1] <= dv_half_reg[j];
                dv_r_reg[j+1]    <= r_next;
                dv_q_reg[j+1]    <= q_next;
                for (int k = 0; k < 3; k++)
                begin
                    dv_low_reg[j+1][k] <= {dv_low_reg[j][k][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        logic signed [PUSH_W-1:0]  p;
        logic signed [PUSH_W-1:0]  q;
        logic [2:0][COORD_W-1:0]   c0;
        logic [2:0][COORD_W-1:0]   c1;
        for (int k = 0; k < 3; k++)
        begin
            q = $signed({1'b0, dv_q_reg[QUO_W][k]});
            unique case (dv_word_reg[QUO_W].kind)
                KIND_SEPARATED:
                begin
                    p = dv_neg_reg[QUO_W][k] ? -q : q;
                end
                KIND_COINCIDENT:
                begin
                    p = (k == 0) ? -PUSH_W'(dv_half_reg[QUO_W]) : '0;
                end
                default:
                begin
                    p = '0;
                end
            endcase
            c0[k] = sat(SAT_W'(comp(dv_word_reg[QUO_W].acc0, 2'(k))) + SAT_W'(p));
            c1[k] = sat(SAT_W'(comp(dv_word_reg[QUO_W].acc1, 2'(k))) - SAT_W'(p));
        end
        fin_next.deviation        = dv_word_reg[QUO_W].dev;
        fin_next.first_shift_out  = WORD_W'(c0);
        fin_next.second_shift_out = WORD_W'(c1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            if (oq_push && !oq_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg + 1'b1;
            end
            else if (oq_pop && !oq_push)
            begin
                oq_cnt_reg <= oq_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem_reg[oq_wr_reg] <= fin_next;
        end
    end

`ifndef ASSERT_OFF
    a_satisfied_zero_dev: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[QUO_W] && dv_word_reg[QUO_W].kind == KIND_SATISFIED)
            |-> dv_word_reg[QUO_W].dev == '0)
        else $error("satisfied word with nonzero deviation");
    a_coincident_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (b0_valid_reg && b0_reg.kind == KIND_COINCIDENT) |-> b0_reg.len == '0)
        else $error("coincident word with nonzero length");
`endif

endmodule

>>> rtl/distance_constraint_correction.sv
// Top level of the distance constraint correction block.
//
//   channel   handshake          word
//   input     push / full        item   (in_word_t)
//   result    pop  / empty       result (out_word_t)
//
// One word per cycle sustained; on its way to the result ports a word passes the
// 22-step square root in the front and the 24-step divide in the back.
// Front and back each stall as a whole only when their downstream queue is full.
// full depends only on registered state; rst_n clears all valid and queue state.
module distance_constraint_correction
    import dcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_word_t  item,
    output logic      empty,
    input  logic      pop,
    output out_word_t result
);

    logic      f_valid;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    mid_word_t f_word;
    mid_word_t q_word;

    dcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .mid_valid (f_valid),
        .mid_full  (q_full),
        .mid       (f_word)
    );

    dcc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid),
        .full  (q_full),
        .din   (f_word),
        .empty (q_empty),
        .pop   (q_pop),
        .dout  (q_word)
    );

    dcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (q_empty),
        .mid_pop   (q_pop),
        .mid       (q_word),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
